### rtl/pfc_pkg.sv
`default_nettype none
package pfc_pkg;

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LETTER_Z = 5'd25;
  localparam logic [4:0] CELLS    = 5'd25;
  localparam logic [6:0] ASCII_A  = 7'd65;

  typedef enum logic [1:0] {
    REQ_KEY      = 2'd0,
    REQ_KEY_DONE = 2'd1,
    REQ_TEXT     = 2'd2,
    REQ_END      = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_POS,
    S_SQ
  } state_t;

  typedef struct packed {
    logic       ok;
    logic [4:0] idx;
  } letter_t;

  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
  } rc_t;

  // upper/lower case letter to index, j folded to i
  function automatic letter_t letter_of(input logic [7:0] b);
    letter_t    res;
    logic [7:0] d;
    res = '0;
    d   = '0;
    if (b >= 8'd65 && b <= 8'd90) begin
      d      = b - 8'd65;
      res.ok = 1'b1;
    end else if (b >= 8'd97 && b <= 8'd122) begin
      d      = b - 8'd97;
      res.ok = 1'b1;
    end
    res.idx = d[4:0];
    if (res.idx == LETTER_J) begin
      res.idx = LETTER_I;
    end
    return res;
  endfunction

  function automatic rc_t split5(input logic [4:0] pos);
    rc_t res;
    res = '0;
    if (pos >= 5'd20) begin
      res.row = 3'd4;
      res.col = 3'(pos - 5'd20);
    end else if (pos >= 5'd15) begin
      res.row = 3'd3;
      res.col = 3'(pos - 5'd15);
    end else if (pos >= 5'd10) begin
      res.row = 3'd2;
      res.col = 3'(pos - 5'd10);
    end else if (pos >= 5'd5) begin
      res.row = 3'd1;
      res.col = 3'(pos - 5'd5);
    end else begin
      res.row = 3'd0;
      res.col = pos[2:0];
    end
    return res;
  endfunction

  // shift by one along a row or column, wrapping at five
  function automatic logic [2:0] shift5(input logic [2:0] x, input logic back);
    logic [2:0] res;
    if (back) begin
      res = (x == 3'd0) ? 3'd4 : x - 3'd1;
    end else begin
      res = (x >= 3'd4) ? 3'd0 : x + 3'd1;
    end
    return res;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    logic [4:0] rr;
    rr = {2'b00, r};
    return (rr << 2) + rr + {2'b00, c};
  endfunction

endpackage
`default_nettype wire

### rtl/playfair_digraph_cipher.sv
`default_nettype none
// Playfair cipher on a 5x5 square held in two small synchronous memories: the
// square (cell to letter) and the position table (letter to cell). Keyword
// bytes are accepted in the idle state. A key-done transaction is accepted and
// then walks the letters A to Z through the single write port of both
// memories. A text byte that completes a digraph, or an end of message with a
// letter pending, is handled in order: accept with the two position reads
// issued, then the two square reads, then the pair lands in the output
// register; the next transaction is accepted while the pair waits there, and
// a further pair waits in the square read stage until the output register is
// free. Text before the key is complete is dropped. decrypt_mode selects
// forward (0) or backward (1) shifting.
module playfair_digraph_cipher (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic                cfg_decrypt_mode,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [7:0]          in_char_byte,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [6:0]               out_letter,
  output logic                     out_pair_last
);
  import pfc_pkg::*;

  logic [4:0] sq_mem  [0:24];
  logic [4:0] pos_mem [0:25];

  state_t     state_r, state_nxt;
  logic       dec_mode_r;
  logic [25:0] used_r, used_nxt;
  logic [4:0] fill_cnt_r, fill_cnt_nxt;
  logic [4:0] fill_idx_r, fill_idx_nxt;
  logic       key_done_r, key_done_nxt;
  logic [4:0] pend_letter_r, pend_letter_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic       ob_valid_r, ob_valid_nxt;
  logic       ob_sec_r, ob_sec_nxt;
  logic [6:0] ob_a_r, ob_b_r;
  logic [4:0] pos_a_r, pos_b_r;
  logic [4:0] sq_a_r, sq_b_r;

  logic       in_fire;
  req_t       req;
  letter_t    lt;
  logic       cand_en;
  logic [4:0] cand;
  logic       place_en;
  logic       pair_go;
  logic [4:0] pair_a, pair_b;
  logic       ob_free;
  logic       ob_load;
  logic       fill_last;
  rc_t        rc_a, rc_b;
  logic [4:0] cell_a, cell_b;

  assign req       = req_t'(in_req_type);
  assign lt        = letter_of(in_char_byte);
  assign in_fire   = in_valid && in_ready;
  assign fill_last = (fill_idx_r == LETTER_Z);
  assign ob_free   = !ob_valid_r || (out_ready && ob_sec_r);
  assign ob_load   = (state_r == S_SQ) && ob_free;
  assign rc_a      = split5(pos_a_r);
  assign rc_b      = split5(pos_b_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && req == REQ_KEY_DONE && !key_done_r) begin
          state_nxt = S_FILL;
        end else if (pair_go) begin
          state_nxt = S_POS;
        end
      end
      S_FILL: begin
        if (fill_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_POS:   state_nxt = S_SQ;
      S_SQ: begin
        if (ob_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and datapath outputs
  always_comb begin
    in_ready        = (state_r == S_IDLE);
    cand_en         = 1'b0;
    cand            = lt.idx;
    pair_go         = 1'b0;
    pair_a          = pend_letter_r;
    pair_b          = LETTER_X;
    pend_letter_nxt = pend_letter_r;
    pend_valid_nxt  = pend_valid_r;
    fill_idx_nxt    = fill_idx_r;
    key_done_nxt    = key_done_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (req)
            REQ_KEY: begin
              cand_en = lt.ok && !key_done_r;
            end
            REQ_KEY_DONE: begin
              fill_idx_nxt = '0;
            end
            REQ_TEXT: begin
              if (key_done_r && lt.ok) begin
                if (!pend_valid_r) begin
                  pend_letter_nxt = lt.idx;
                  pend_valid_nxt  = 1'b1;
                end else if (lt.idx == pend_letter_r) begin
                  pair_go = 1'b1;
                end else begin
                  pair_go         = 1'b1;
                  pair_b          = lt.idx;
                  pend_letter_nxt = '0;
                  pend_valid_nxt  = 1'b0;
                end
              end
            end
            REQ_END: begin
              if (key_done_r && pend_valid_r) begin
                pair_go         = 1'b1;
                pend_letter_nxt = '0;
                pend_valid_nxt  = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        cand         = fill_idx_r;
        cand_en      = (fill_idx_r != LETTER_J);
        fill_idx_nxt = fill_idx_r + 5'd1;
        if (fill_last) begin
          key_done_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    place_en     = cand_en && !used_r[cand] && (fill_cnt_r < CELLS);
    used_nxt     = used_r;
    fill_cnt_nxt = fill_cnt_r;
    if (place_en) begin
      used_nxt[cand] = 1'b1;
      fill_cnt_nxt   = fill_cnt_r + 5'd1;
    end

    if (rc_a.row == rc_b.row) begin
      cell_a = cell_of(rc_a.row, shift5(rc_a.col, dec_mode_r));
      cell_b = cell_of(rc_b.row, shift5(rc_b.col, dec_mode_r));
    end else if (rc_a.col == rc_b.col) begin
      cell_a = cell_of(shift5(rc_a.row, dec_mode_r), rc_a.col);
      cell_b = cell_of(shift5(rc_b.row, dec_mode_r), rc_b.col);
    end else begin
      cell_a = cell_of(rc_a.row, rc_b.col);
      cell_b = cell_of(rc_b.row, rc_a.col);
    end

    ob_valid_nxt = ob_valid_r;
    ob_sec_nxt   = ob_sec_r;
    if (ob_valid_r && out_ready) begin
      if (ob_sec_r) begin
        ob_valid_nxt = 1'b0;
        ob_sec_nxt   = 1'b0;
      end else begin
        ob_sec_nxt = 1'b1;
      end
    end
    if (ob_load) begin
      ob_valid_nxt = 1'b1;
      ob_sec_nxt   = 1'b0;
    end
  end

  assign out_valid     = ob_valid_r;
  assign out_pair_last = ob_sec_r;
  assign out_letter    = ob_sec_r ? ob_b_r : ob_a_r;

  // the square and the position table are written only before the key is
  // complete and read only after, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (place_en) begin
      sq_mem[fill_cnt_r] <= cand;
      pos_mem[cand]      <= fill_cnt_r;
    end
    if (pair_go) begin
      pos_a_r <= pos_mem[pair_a];
      pos_b_r <= pos_mem[pair_b];
    end
    if (state_r == S_POS) begin
      sq_a_r <= sq_mem[cell_a];
      sq_b_r <= sq_mem[cell_b];
    end
    if (ob_load) begin
      ob_a_r <= ASCII_A + {2'b00, sq_a_r};
      ob_b_r <= ASCII_A + {2'b00, sq_b_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      dec_mode_r    <= 1'b0;
      used_r        <= '0;
      fill_cnt_r    <= '0;
      fill_idx_r    <= '0;
      key_done_r    <= 1'b0;
      pend_letter_r <= '0;
      pend_valid_r  <= 1'b0;
      ob_valid_r    <= 1'b0;
      ob_sec_r      <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      if (cfg_wr_en) begin
        dec_mode_r <= cfg_decrypt_mode;
      end
      used_r        <= used_nxt;
      fill_cnt_r    <= fill_cnt_nxt;
      fill_idx_r    <= fill_idx_nxt;
      key_done_r    <= key_done_nxt;
      pend_letter_r <= pend_letter_nxt;
      pend_valid_r  <= pend_valid_nxt;
      ob_valid_r    <= ob_valid_nxt;
      ob_sec_r      <= ob_sec_nxt;
    end
  end

  a_sec_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ob_sec_r |-> ob_valid_r)
    else $error("second letter flagged with empty output register");

  a_key_stays: assert property (@(posedge clk) disable iff (!rst_n)
    key_done_r |=> key_done_r)
    else $error("key complete flag dropped");

  a_square_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(key_done_r) |-> (fill_cnt_r == CELLS))
    else $error("square not full when key completes");

  a_pend_no_j: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_letter_r != LETTER_J))
    else $error("pending letter is j");

endmodule
`default_nettype wire

### dv/tb_playfair_digraph_cipher.sv
`timescale 1ns / 1ps
module tb_playfair_digraph_cipher;
  import pfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    req_t       req;
    logic [7:0] ch;
  } text_item_t;

  typedef struct {
    logic [6:0] letter;
    logic       last;
  } cipher_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_decrypt_mode = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = REQ_KEY;
  logic [7:0] in_char_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] out_letter;
  logic       out_pair_last;

  text_item_t  item_q[$];
  text_item_t  cur_item;
  cipher_out_t cipher_letters_q[$];

  // predicted block state
  logic [4:0]  sq_letter[25];
  logic [4:0]  sq_pos[26];
  logic [25:0] used = '0;
  int          fill_cnt = 0;
  bit          key_done = 1'b0;
  logic [4:0]  pend_let = '0;
  bit          pend_vld = 1'b0;
  bit          mode_r = 1'b0;

  bit calm = 1'b0;
  int n_err = 0;
  int n_cycles = 0;
  int n_accepted = 0;
  int n_results = 0;
  int n_row = 0;
  int n_col = 0;
  int n_rect = 0;
  int n_enc = 0;
  int n_dec = 0;

  playfair_digraph_cipher u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_decrypt_mode(cfg_decrypt_mode),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_char_byte    (in_char_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_letter      (out_letter),
    .out_pair_last   (out_pair_last)
  );

  always #1 clk = ~clk;

  task automatic place_letter(input logic [4:0] l);
    if (fill_cnt < 25 && !used[l]) begin
      sq_letter[fill_cnt] = l;
      sq_pos[l] = 5'(fill_cnt);
      used[l] = 1'b1;
      fill_cnt++;
    end
  endtask

  task automatic queue_pair(input logic [4:0] a, input logic [4:0] b);
    int          pa, pb, ra, ca, rb, cb, step;
    logic [4:0]  x0, x1;
    cipher_out_t e;
    pa = sq_pos[a];
    pb = sq_pos[b];
    ra = pa / 5;
    ca = pa % 5;
    rb = pb / 5;
    cb = pb % 5;
    step = mode_r ? 4 : 1;
    if (ra == rb) begin
      x0 = sq_letter[ra * 5 + (ca + step) % 5];
      x1 = sq_letter[rb * 5 + (cb + step) % 5];
      n_row++;
    end else if (ca == cb) begin
      x0 = sq_letter[((ra + step) % 5) * 5 + ca];
      x1 = sq_letter[((rb + step) % 5) * 5 + cb];
      n_col++;
    end else begin
      x0 = sq_letter[ra * 5 + cb];
      x1 = sq_letter[rb * 5 + ca];
      n_rect++;
    end
    if (mode_r) begin
      n_dec++;
    end else begin
      n_enc++;
    end
    e.letter = ASCII_A + 7'(x0);
    e.last = 1'b0;
    cipher_letters_q.push_back(e);
    e.letter = ASCII_A + 7'(x1);
    e.last = 1'b1;
    cipher_letters_q.push_back(e);
  endtask

  task automatic cipher_step(input req_t r, input logic [7:0] c);
    logic       ok;
    logic [4:0] l;
    ok = 1'b0;
    l = '0;
    if (c >= "A" && c <= "Z") begin
      ok = 1'b1;
      l = 5'(c - "A");
    end else if (c >= "a" && c <= "z") begin
      ok = 1'b1;
      l = 5'(c - "a");
    end
    if (ok && l == LETTER_J) begin
      l = LETTER_I;
    end
    case (r)
      REQ_KEY: begin
        if (!key_done && ok) begin
          place_letter(l);
        end
      end
      REQ_KEY_DONE: begin
        if (!key_done) begin
          for (int i = 0; i < 26; i++) begin
            if (5'(i) != LETTER_J) begin
              place_letter(5'(i));
            end
          end
          key_done = 1'b1;
        end
      end
      REQ_TEXT: begin
        if (key_done && ok) begin
          if (!pend_vld) begin
            pend_let = l;
            pend_vld = 1'b1;
          end else if (l == pend_let) begin
            // doubled letter: x goes in, the letter stays pending
            queue_pair(pend_let, LETTER_X);
          end else begin
            queue_pair(pend_let, l);
            pend_vld = 1'b0;
          end
        end
      end
      default: begin
        if (key_done && pend_vld) begin
          queue_pair(pend_let, LETTER_X);
          pend_vld = 1'b0;
        end
      end
    endcase
  endtask

  task automatic push(input req_t r, input logic [7:0] c);
    text_item_t t;
    t.req = r;
    t.ch = c;
    item_q.push_back(t);
  endtask

  function automatic logic [7:0] any_letter();
    logic [7:0] base;
    base = $urandom_range(1) ? 8'd65 : 8'd97;
    return base + 8'($urandom_range(25));
  endfunction

  task automatic push_text_run(input int n);
    int         i;
    int         roll;
    logic [7:0] c;
    i = 0;
    while (i < n) begin
      roll = $urandom_range(99);
      c = any_letter();
      if (roll < 60) begin
        push(REQ_TEXT, c);
        i++;
      end else if (roll < 70) begin
        push(REQ_TEXT, c);
        push(REQ_TEXT, c ^ 8'h20);
        i += 2;
      end else if (roll < 78) begin
        push(REQ_END, 8'($urandom_range(255)));
        i++;
      end else if (roll < 86) begin
        push(REQ_TEXT, 8'($urandom_range(255)));
        i++;
      end else if (roll < 90) begin
        push(REQ_KEY, 8'($urandom_range(255)));
      end else if (roll < 92) begin
        push(REQ_KEY_DONE, 8'($urandom_range(255)));
      end else if (roll < 96) begin
        push(REQ_TEXT, $urandom_range(1) ? "X" : "x");
        i++;
      end else begin
        push(REQ_TEXT, $urandom_range(1) ? "J" : "i");
        i++;
      end
    end
  endtask

  task automatic wait_idle();
    while (item_q.size() > 0 || in_valid || cipher_letters_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input bit m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_decrypt_mode <= m;
    mode_r = m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin : drv
    logic fire;
    fire = in_valid && in_ready;
    if (fire) begin
      cipher_step(cur_item.req, cur_item.ch);
      n_accepted++;
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || fire) begin
      if (item_q.size() > 0 && (calm || $urandom_range(99) >= 24)) begin
        cur_item = item_q.pop_front();
        in_valid <= 1'b1;
        in_req_type <= cur_item.req;
        in_char_byte <= cur_item.ch;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= calm || $urandom_range(99) >= 24;
  end

  // monitor
  always @(posedge clk) begin : mon
    cipher_out_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (cipher_letters_q.size() == 0) begin
        $error("unexpected transaction: out_letter %0d out_pair_last %0d",
               out_letter, out_pair_last);
        n_err++;
      end else begin
        e = cipher_letters_q.pop_front();
        if (out_letter !== e.letter) begin
          $error("out_letter mismatch: expected %0d, actual %0d", e.letter, out_letter);
          n_err++;
        end
        if (out_pair_last !== e.last) begin
          $error("out_pair_last mismatch: expected %0d, actual %0d", e.last,
                 out_pair_last);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n_key;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b0);

    // text before the key is complete is dropped
    push(REQ_TEXT, "A");
    push(REQ_END, "A");
    push(REQ_KEY, 8'h00);
    push(REQ_KEY, 8'hFF);
    push(REQ_KEY, "j");
    push(REQ_KEY, "I");
    push(REQ_KEY, "p");
    push(REQ_KEY, "P");
    n_key = $urandom_range(4, 14);
    repeat (n_key) begin
      if ($urandom_range(99) < 85) begin
        push(REQ_KEY, any_letter());
      end else begin
        push(REQ_KEY, 8'($urandom_range(255)));
      end
    end
    push(REQ_KEY_DONE, 8'h00);
    push(REQ_KEY_DONE, 8'hFF);
    push(REQ_KEY, "Q");
    push(REQ_END, "x");
    push(REQ_TEXT, "A");
    push(REQ_TEXT, "a");
    push(REQ_TEXT, "z");
    push(REQ_TEXT, "J");
    push(REQ_TEXT, "i");
    push(REQ_TEXT, 8'h00);
    push(REQ_TEXT, "X");
    push(REQ_TEXT, "X");
    push(REQ_TEXT, "x");
    push(REQ_END, 8'hFF);
    push(REQ_TEXT, "Z");
    push(REQ_TEXT, 8'hFF);
    push(REQ_END, 8'h00);
    push(REQ_TEXT, "b");
    push(REQ_TEXT, "Y");
    wait_idle();

    write_mode(1'b1);
    push_text_run(110);
    wait_idle();

    // no stalls on either side for this stretch
    write_mode(1'b0);
    calm = 1'b1;
    push_text_run(110);
    wait_idle();
    calm = 1'b0;

    write_mode(1'b1);
    push_text_run(110);
    wait_idle();

    write_mode(1'b0);
    push_text_run(100);
    wait_idle();

    $display("covered %0d transactions in, %0d letters out; %0d encrypt, %0d decrypt pairs",
             n_accepted, n_results, n_enc, n_dec);
    $display("pairs by rule: %0d same row, %0d same column, %0d rectangle",
             n_row, n_col, n_rect);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pfc_pkg.sv
rtl/playfair_digraph_cipher.sv
dv/tb_playfair_digraph_cipher.sv
